// ===== sv/kmst_pkg.sv =====
`default_nettype none
package kmst_pkg;

  typedef logic [5:0] node_t;

  typedef struct packed {
    node_t       src;
    node_t       dst;
    logic [31:0] weight;
    logic [15:0] prob;
  } edge_t;

  typedef struct packed {
    node_t       src_node;
    node_t       dst_node;
    logic [31:0] edge_weight;
    logic [15:0] edge_prob;
    logic        graph_end;
  } in_item_t;

  typedef struct packed {
    node_t       tree_src;
    node_t       tree_dst;
    logic [31:0] tree_weight;
    logic        has_edge;
    logic        last_result;
    logic        tree_complete;
    logic        edges_dropped;
  } out_item_t;

  // parent table write / clear control
  typedef struct packed {
    logic  we;
    logic  clr;
    node_t addr;
    node_t data;
  } uf_wr_t;

  localparam logic REG_NUM_NODES   = 1'b0;
  localparam logic REG_HYBRID_MODE = 1'b1;

  // strict order: weight up, then (hybrid) prob down, then load order
  function automatic logic goes_before(input logic [31:0] aw, input logic [15:0] ap,
                                       input logic [15:0] ai, input logic [31:0] bw,
                                       input logic [15:0] bp, input logic [15:0] bi,
                                       input logic hyb);
    logic r;
    if (aw != bw) r = aw < bw;
    else if (hyb && ap != bp) r = ap > bp;
    else r = ai < bi;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/kmst_edge_ram.sv =====
`default_nettype none
module kmst_edge_ram import kmst_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire edge_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output edge_t              rdata
);
  edge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/kmst_parent_ram.sv =====
`default_nettype none
module kmst_parent_ram import kmst_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire uf_wr_t wr,
  input  wire node_t  raddr,
  output node_t       rdata,
  output logic        rvalid
);
  localparam int AW = $clog2(DEPTH);

  node_t            mem [DEPTH];
  logic [DEPTH-1:0] vld;   // entry not valid: node is its own parent

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rdata <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr) begin
      vld <= '0;
    end else if (wr.we) begin
      vld[wr.addr[AW-1:0]] <= 1'b1;
    end
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= vld[raddr[AW-1:0]] && !wr.clr;
    end
  end
endmodule
`default_nettype wire

// ===== sv/kruskal_minimum_spanning_tree.sv =====
`default_nettype none
// Channel  | Handshake          | Payload            | Notes
// ---------+--------------------+--------------------+------------------------------
// in       | in_valid/in_ready  | in_item (edge)     | one edge per item, graph_end closes graph
// out      | out_valid/out_ready| out_item (result)  | kept edges in scan order, last marked
// cfg      | cfg_we             | cfg_index,cfg_data | write only while idle
//
// Loading: one edge per cycle into the edge store memory; in_ready is low while solving.
// Solve: sorted order is produced on the fly; each candidate edge costs one sweep of the
// store and, with both endpoints in range, a root walk over the parent memory from both
// endpoints and a union step. If the first pass keeps any edge the scan runs twice: the
// first counts kept edges so tree_complete and last_result are known, the second emits.
// Reset: control clears; parent entries use valid bits, no sweep.
// A full output register stalls the emitting pass.
module kruskal_minimum_spanning_tree import kmst_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [6:0] cfg_data
);
  localparam int EIW = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int NIW = $clog2(MAX_NODES);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_UNION = 3'd5;
  localparam logic [2:0] S_ENDP  = 3'd6;

  logic [2:0]    state;
  logic [6:0]    node_count;
  logic          hybrid_mode;
  logic [CW-1:0] edge_count;
  logic          overflow;
  logic          pass2;
  logic [6:0]    kept;
  logic [6:0]    kept_total;
  logic [CW-1:0] sweep;      // next store address to read
  logic          dvld;       // store read data valid this cycle
  logic [CW-1:0] didx;       // index of that data
  logic          have_best, have_prev;
  edge_t         best_e, prev_e;
  logic [CW-1:0] best_i, prev_i;
  logic [NIW-1:0] cur, ra, rb;
  logic          which;      // 0: walking from src, 1: from dst

  // clamp node_count into 1..MAX_NODES
  logic [6:0] n_eff, target;
  always_comb begin
    if (node_count == 7'd0) n_eff = 7'd1;
    else if (node_count > 7'(MAX_NODES)) n_eff = 7'(MAX_NODES);
    else n_eff = node_count;
    target = n_eff - 7'd1;
  end

  // memories
  logic           st_we;
  edge_t          st_rdata;
  edge_t          st_wdata;
  uf_wr_t         uf_wr;
  node_t          par_raddr, par_rdata;
  logic           par_rvalid;

  assign st_we    = in_valid && in_ready && (edge_count < CW'(MAX_EDGES));
  assign st_wdata = '{src: in_item.src_node, dst: in_item.dst_node,
                      weight: in_item.edge_weight, prob: in_item.edge_prob};

  kmst_edge_ram #(.DEPTH(MAX_EDGES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (edge_count[EIW-1:0]),
    .wdata (st_wdata),
    .raddr (sweep[EIW-1:0]),
    .rdata (st_rdata)
  );

  kmst_parent_ram #(.DEPTH(MAX_NODES)) u_parent (
    .clk    (clk),
    .rst    (rst),
    .wr     (uf_wr),
    .raddr  (par_raddr),
    .rdata  (par_rdata),
    .rvalid (par_rvalid)
  );

  assign in_ready = (state == S_LOAD);

  // candidate from the sweep: after prev in sort order, before current best
  logic cand_ok, sweep_done, out_free, edge_in_range, emit;
  logic [NIW-1:0] pv;
  always_comb begin
    cand_ok = dvld
      && (!have_prev || goes_before(prev_e.weight, prev_e.prob, 16'(prev_i),
                                    st_rdata.weight, st_rdata.prob, 16'(didx),
                                    hybrid_mode))
      && (!have_best || goes_before(st_rdata.weight, st_rdata.prob, 16'(didx),
                                    best_e.weight, best_e.prob, 16'(best_i),
                                    hybrid_mode));
    sweep_done    = (sweep == edge_count) && !dvld;
    out_free      = !out_valid || out_ready;
    edge_in_range = ({1'b0, best_e.src} < n_eff) && ({1'b0, best_e.dst} < n_eff);
    pv            = par_rvalid ? par_rdata[NIW-1:0] : cur;
    // a result is loaded: kept edge in the emitting pass, or the empty result
    emit = out_free && (((state == S_UNION) && pass2 && (ra != rb))
                        || ((state == S_ENDP) && !pass2 && (kept == 7'd0)));
  end

  // parent memory read address and write control
  always_comb begin
    par_raddr = 6'(cur);
    uf_wr     = '{we: 1'b0, clr: 1'b0, addr: 6'(ra), data: 6'(rb)};
    case (state)
      S_INIT: uf_wr.clr = 1'b1;
      S_SCAN: par_raddr = best_e.src;
      S_FIND: begin
        if (pv == cur) par_raddr = best_e.dst;
        else par_raddr = 6'(pv);
      end
      S_UNION: uf_wr.we = (ra != rb) && (!pass2 || out_free);
      S_ENDP: uf_wr.clr = !pass2 && (kept != 7'd0);
      default: ;
    endcase
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= 7'd64;
      hybrid_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_NODES:   node_count  <= cfg_data;
        REG_HYBRID_MODE: hybrid_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      edge_count <= '0;
      overflow   <= 1'b0;
      pass2      <= 1'b0;
      kept       <= '0;
      kept_total <= '0;
      sweep      <= '0;
      dvld       <= 1'b0;
      have_best  <= 1'b0;
      have_prev  <= 1'b0;
      which      <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (edge_count < CW'(MAX_EDGES)) edge_count <= edge_count + CW'(1);
            else overflow <= 1'b1;
            if (in_item.graph_end) state <= S_INIT;
          end
        end
        S_INIT: begin
          pass2     <= 1'b0;
          kept      <= '0;
          have_prev <= 1'b0;
          state     <= S_SEL;
        end
        S_SEL: begin
          if (kept == target) begin
            state <= S_ENDP;
          end else begin
            sweep     <= '0;
            dvld      <= 1'b0;
            have_best <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sweep != edge_count) begin
            dvld  <= 1'b1;
            didx  <= sweep;
            sweep <= sweep + CW'(1);
          end else begin
            dvld <= 1'b0;
          end
          if (cand_ok) begin
            have_best <= 1'b1;
            best_e    <= st_rdata;
            best_i    <= didx;
          end
          if (sweep_done) begin
            if (!have_best) begin
              state <= S_ENDP;
            end else if (!edge_in_range) begin
              prev_e    <= best_e;
              prev_i    <= best_i;
              have_prev <= 1'b1;
              state     <= S_SEL;
            end else begin
              cur   <= best_e.src[NIW-1:0];
              which <= 1'b0;
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (pv == cur) begin
            if (!which) begin
              ra    <= cur;
              cur   <= best_e.dst[NIW-1:0];
              which <= 1'b1;
            end else begin
              rb    <= cur;
              state <= S_UNION;
            end
          end else begin
            cur <= pv;
          end
        end
        S_UNION: begin
          if (ra == rb || !pass2 || out_free) begin
            if (ra != rb) begin
              kept <= kept + 7'd1;
              if (pass2) begin
                out_item  <= '{tree_src: best_e.src, tree_dst: best_e.dst,
                               tree_weight: best_e.weight, has_edge: 1'b1,
                               last_result: (kept + 7'd1 == kept_total),
                               tree_complete: (kept_total == target),
                               edges_dropped: overflow};
              end
            end
            prev_e    <= best_e;
            prev_i    <= best_i;
            have_prev <= 1'b1;
            state     <= S_SEL;
          end
        end
        S_ENDP: begin
          if (pass2) begin
            edge_count <= '0;
            overflow   <= 1'b0;
            pass2      <= 1'b0;
            kept       <= '0;
            state      <= S_LOAD;
          end else if (kept != 7'd0) begin
            // replay the scan, this time emitting
            kept_total <= kept;
            kept       <= '0;
            have_prev  <= 1'b0;
            pass2      <= 1'b1;
            state      <= S_SEL;
          end else if (out_free) begin
            out_item   <= '{tree_src: '0, tree_dst: '0, tree_weight: '0,
                            has_edge: 1'b0, last_result: 1'b1,
                            tree_complete: (target == 7'd0),
                            edges_dropped: overflow};
            edge_count <= '0;
            overflow   <= 1'b0;
            state      <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // never keep more than the tree needs
  a_kept_bound: assert property (@(posedge clk) disable iff (rst) kept <= target)
    else $error("kept count above target");

  // the emitting pass never exceeds the count found by the first pass
  a_replay_bound: assert property (@(posedge clk) disable iff (rst)
    pass2 |-> kept <= kept_total)
    else $error("replay kept more edges than counting pass");

  // root walk stays inside the active nodes
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> ({1'b0, 6'(cur)} < n_eff))
    else $error("root walk left the node range");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
  import kmst_pkg::*;

  localparam int NODES     = 64;
  localparam int EDGE_CAP  = 1024;
  localparam int CYCLE_CAP = 5000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_index;
  logic [6:0] cfg_data;

  kruskal_minimum_spanning_tree u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pending edges for the driver, tree edges still owed by the block
  in_item_t  edge_q[$];
  out_item_t tree_q[$];

  // mirror of the block: registers and the graph being loaded
  logic [6:0] node_reg;
  logic       hybrid_reg;
  edge_t      graph[$];
  logic       graph_dropped;

  int  errors;
  int  cycles;
  logic in_taken;
  logic calm;     // when set, neither side idles

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // strict order used by the sort: lighter first, then (hybrid) likelier first
  function automatic bit lighter(edge_t a, edge_t b);
    if (a.weight != b.weight) return a.weight < b.weight;
    return hybrid_reg && a.prob > b.prob;
  endfunction

  // sort the loaded graph, run union-find, queue the resulting tree items
  task automatic solve_tree();
    edge_t      key;
    edge_t      e;
    logic [5:0] parent[NODES];
    int         n, j, ra, rb, kept, first;
    out_item_t  r;
    n = (node_reg == 0) ? 1 : (node_reg > NODES) ? NODES : node_reg;
    // stable insertion sort, exact ties stay in load order
    for (int i = 1; i < graph.size(); i++) begin
      key = graph[i];
      j = i;
      while (j > 0 && lighter(key, graph[j-1])) begin
        graph[j] = graph[j-1];
        j--;
      end
      graph[j] = key;
    end
    for (int k = 0; k < NODES; k++) parent[k] = 6'(k);
    kept = 0;
    first = tree_q.size();
    for (int i = 0; i < graph.size() && kept < n - 1; i++) begin
      e = graph[i];
      if (e.src >= n || e.dst >= n) continue;
      ra = e.src;
      while (parent[ra] != ra) ra = parent[ra];
      rb = e.dst;
      while (parent[rb] != rb) rb = parent[rb];
      if (ra != rb) begin
        parent[ra] = 6'(rb);
        r = '0;
        r.tree_src = e.src;
        r.tree_dst = e.dst;
        r.tree_weight = e.weight;
        r.has_edge = 1'b1;
        tree_q.push_back(r);
        kept++;
      end
    end
    // nothing kept: a single empty item stands for the run
    if (kept == 0) tree_q.push_back('0);
    for (int k = first; k < tree_q.size(); k++) begin
      tree_q[k].last_result   = (k == tree_q.size() - 1);
      tree_q[k].tree_complete = (kept == n - 1);
      tree_q[k].edges_dropped = graph_dropped;
    end
    graph.delete();
    graph_dropped = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // monitor: predicts on accepted edges, checks accepted tree items
  always @(posedge clk) begin
    edge_t     e;
    out_item_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (tree_q.size() == 0) begin
          $error("tree item with nothing expected: %p", out_item);
          errors++;
        end else begin
          want = tree_q.pop_front();
          check_field("tree_src", 32'(want.tree_src), 32'(out_item.tree_src));
          check_field("tree_dst", 32'(want.tree_dst), 32'(out_item.tree_dst));
          check_field("tree_weight", want.tree_weight, out_item.tree_weight);
          check_field("has_edge", 32'(want.has_edge), 32'(out_item.has_edge));
          check_field("last_result", 32'(want.last_result), 32'(out_item.last_result));
          check_field("tree_complete", 32'(want.tree_complete),
                      32'(out_item.tree_complete));
          check_field("edges_dropped", 32'(want.edges_dropped),
                      32'(out_item.edges_dropped));
        end
      end
      if (in_valid && in_ready) begin
        if (graph.size() < EDGE_CAP) begin
          e.src = in_item.src_node;
          e.dst = in_item.dst_node;
          e.weight = in_item.edge_weight;
          e.prob = in_item.edge_prob;
          graph.push_back(e);
        end else begin
          graph_dropped = 1'b1;   // store full, edge lost
        end
        if (in_item.graph_end) solve_tree();
      end
    end
  end

  // driver: one change per signal per falling edge
  always @(negedge clk) begin
    logic     v;
    in_item_t it;
    if (!rst) begin
      v = in_valid;
      it = in_item;
      if (in_valid && in_taken) v = 1'b0;
      if (!v && edge_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
        it = edge_q.pop_front();
        v = 1'b1;
      end
      in_valid <= v;
      in_item <= it;
      out_ready <= calm || $urandom_range(99) >= 22;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic push_edge(int s, int d, logic [31:0] w, logic [15:0] p, bit last);
    in_item_t it;
    it.src_node = 6'(s);
    it.dst_node = 6'(d);
    it.edge_weight = w;
    it.edge_prob = p;
    it.graph_end = last;
    edge_q.push_back(it);
  endtask

  // block idle: nothing queued or owed, solve finished, then a margin
  task automatic settle();
    while (edge_q.size() > 0 || in_valid || tree_q.size() > 0 || !in_ready)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_NUM_NODES) node_reg = val;
    else hybrid_reg = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random graph; mostly endpoints in range with clustered weights for ties
  task automatic random_graph(int span, int count);
    int          s, d;
    logic [31:0] w;
    logic [15:0] p;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(99) < 15) ? $urandom_range(63) : $urandom_range(span - 1);
      d = ($urandom_range(99) < 15) ? $urandom_range(63) : $urandom_range(span - 1);
      w = ($urandom_range(1)) ? ($urandom_range(7) << 16) : $urandom;
      p = ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom_range(16'hFFFF));
      push_edge(s, d, w, p, i == count - 1);
    end
  endtask

  initial begin
    int sent, span, cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NUM_NODES;
    cfg_data = '0;
    node_reg = 7'd64;
    hybrid_reg = 1'b0;
    graph_dropped = 1'b0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full node range, extremes of every field, self loop, exact tie
    write_reg(REG_NUM_NODES, 7'd64);
    write_reg(REG_HYBRID_MODE, 7'd0);
    push_edge(0, 63, 32'hFFFF_FFFF, 16'hFFFF, 0);
    push_edge(5, 5, 32'd0, 16'd0, 0);
    push_edge(63, 1, 32'd0, 16'h8000, 0);
    push_edge(2, 3, 32'h0001_0000, 16'd1, 0);
    push_edge(3, 2, 32'h0001_0000, 16'd9, 0);
    push_edge(1, 2, 32'h0002_0000, 16'd0, 1);
    settle();

    // hybrid ties: likelier first; one endpoint outside the node range
    write_reg(REG_NUM_NODES, 7'd4);
    write_reg(REG_HYBRID_MODE, 7'd1);
    push_edge(0, 1, 32'h0003_0000, 16'd10, 0);
    push_edge(1, 0, 32'h0003_0000, 16'd50, 0);
    push_edge(2, 9, 32'd0, 16'd0, 0);
    push_edge(1, 2, 32'h0003_0000, 16'd50, 0);
    push_edge(2, 3, 32'h0004_0000, 16'hFFFF, 0);
    push_edge(3, 0, 32'h0001_0000, 16'd0, 1);
    settle();

    // zero nodes act as one: nothing kept, tree still complete
    write_reg(REG_NUM_NODES, 7'd0);
    push_edge(0, 1, 32'd7, 16'd7, 1);
    settle();
    // two nodes, only a self loop: nothing kept, tree incomplete
    write_reg(REG_NUM_NODES, 7'd2);
    push_edge(1, 1, 32'd3, 16'd3, 1);
    settle();
    // node count above the limit is clamped
    write_reg(REG_NUM_NODES, 7'd127);
    write_reg(REG_HYBRID_MODE, 7'd0);
    push_edge(62, 63, 32'h8000_0000, 16'd0, 0);
    push_edge(0, 62, 32'd1, 16'd0, 1);
    settle();

    // random graphs under changing settings, one phase without idling
    sent = 0;
    for (int ph = 0; sent < 110; ph++) begin
      span = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 10);
      write_reg(REG_NUM_NODES,
                ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'(span));
      write_reg(REG_HYBRID_MODE, 7'($urandom_range(1)));
      calm = (ph == 1);
      for (int g = 0; g < 3; g++) begin
        cnt = $urandom_range(1, 14);
        random_graph(span, cnt);
        sent += cnt;
      end
      settle();
    end
    calm = 1'b0;

    // small node count at the end
    write_reg(REG_NUM_NODES, 7'd3);
    random_graph(3, 5);
    settle();

    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/kmst_pkg.sv
sv/kmst_edge_ram.sv
sv/kmst_parent_ram.sv
sv/kruskal_minimum_spanning_tree.sv
test/testbench.sv
